// ===== design/union_find_disjoint_sets_top_assert.svh =====
// Assertion macros shared by the disjoint-set engine.
`ifndef UNION_FIND_DISJOINT_SETS_TOP_ASSERT_SVH
`define UNION_FIND_DISJOINT_SETS_TOP_ASSERT_SVH

// The condition must never hold while out of reset.
`define UFDS_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("disjoint-set engine: forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define UFDS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("disjoint-set engine: implication failed");

`endif

// ===== design/ufds_pkg.sv =====
// Package with the shared types and constants of the disjoint-set engine.
`timescale 1ns / 1ps

package ufds_pkg;

   localparam int NODE_W = 10;

   localparam logic OP_UNION = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND1,
      ST_FIND2,
      ST_ITEM_END,
      ST_SIZE_A,
      ST_SIZE_B
   } state_type;

endpackage

// ===== design/ufds_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ufds_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/union_find_disjoint_sets_top.sv =====
// Disjoint-set engine with union by size and path compression over two RAMs.
// A find makes one pass up the chain to the root, then one rewrite pass that points each node on it at the root.
// A query result is registered in ST_ITEM_END after its finds; a merge of two sets then runs ST_SIZE_A and ST_SIZE_B.
// One parent RAM read per cycle sets the pace; the next beat is taken in the cycle after an item ends.
// After reset a clearing pass loads all min(NODES, 1024) entries of the RAMs, and no beat is taken.
`timescale 1ns / 1ps
`include "union_find_disjoint_sets_top_assert.svh"

module union_find_disjoint_sets_top #(
   parameter int NODES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [ufds_pkg::NODE_W-1:0] req_node_a,
   input  logic [ufds_pkg::NODE_W-1:0] req_node_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_same_set
);

   localparam int MAX_NODES = 1 << ufds_pkg::NODE_W;
   localparam int DEPTH     = (NODES < MAX_NODES) ? NODES : MAX_NODES;
   localparam int AW        = $clog2(DEPTH);
   localparam int SW        = AW + 1;

   ufds_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic          op_ff, op_in;
   logic [AW-1:0] a_ff, a_in;
   logic [AW-1:0] b_ff, b_in;
   logic          need_b_ff, need_b_in;
   logic          both_ok_ff, both_ok_in;
   logic          eq_ff, eq_in;
   logic          sel_ff, sel_in;
   logic [AW-1:0] x_ff, x_in;
   logic [AW-1:0] r_ff, r_in;
   logic [AW-1:0] root_ff, root_in;
   logic [AW-1:0] ra_ff, ra_in;
   logic [AW-1:0] rb_ff, rb_in;
   logic [SW-1:0] size_a_ff, size_a_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_same_set_ff, rsp_same_set_in;

   logic          par_we;
   logic [AW-1:0] par_wa, par_wd, par_ra, par_rd;
   logic          sz_we;
   logic [AW-1:0] sz_wa, sz_ra;
   logic [SW-1:0] sz_wd, sz_rd;
   logic [SW-1:0] size_sum;

   logic          a_ok, b_ok, need_a, need_b;

   ufds_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_wa),
      .wr_data (par_wd),
      .rd_addr (par_ra),
      .rd_data (par_rd)
   );

   ufds_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_size (
      .clock   (clock),
      .wr_en   (sz_we),
      .wr_addr (sz_wa),
      .wr_data (sz_wd),
      .rd_addr (sz_ra),
      .rd_data (sz_rd)
   );

   assign a_ok     = 32'(req_node_a) < NODES;
   assign b_ok     = 32'(req_node_b) < NODES;
   assign need_a   = (req_opcode == ufds_pkg::OP_UNION) ? (a_ok && b_ok) : a_ok;
   assign need_b   = (req_opcode == ufds_pkg::OP_UNION) ? (a_ok && b_ok) : b_ok;
   assign size_sum = size_a_ff + sz_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufds_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      need_b_ff       <= need_b_in;
      both_ok_ff      <= both_ok_in;
      eq_ff           <= eq_in;
      sel_ff          <= sel_in;
      x_ff            <= x_in;
      r_ff            <= r_in;
      root_ff         <= root_in;
      ra_ff           <= ra_in;
      rb_ff           <= rb_in;
      size_a_ff       <= size_a_in;
      rsp_same_set_ff <= rsp_same_set_in;
   end

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      op_in           = op_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      need_b_in       = need_b_ff;
      both_ok_in      = both_ok_ff;
      eq_in           = eq_ff;
      sel_in          = sel_ff;
      x_in            = x_ff;
      r_in            = r_ff;
      root_in         = root_ff;
      ra_in           = ra_ff;
      rb_in           = rb_ff;
      size_a_in       = size_a_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_same_set_in = rsp_same_set_ff;
      req_stall       = 1'b1;
      par_we          = 1'b0;
      par_wa          = r_ff;
      par_wd          = root_ff;
      par_ra          = r_ff;
      sz_we           = 1'b0;
      sz_wa           = ra_ff;
      sz_wd           = size_sum;
      sz_ra           = ra_ff;

      unique case (state_ff)
         ufds_pkg::ST_CLEAR: begin
            par_we = 1'b1;
            par_wa = clr_ff;
            par_wd = clr_ff;
            sz_we  = 1'b1;
            sz_wa  = clr_ff;
            sz_wd  = SW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ufds_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         ufds_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in      = req_opcode;
               a_in       = req_node_a[AW-1:0];
               b_in       = req_node_b[AW-1:0];
               need_b_in  = need_b;
               both_ok_in = a_ok && b_ok;
               eq_in      = (req_node_a == req_node_b);
               priority if (need_a) begin
                  x_in     = req_node_a[AW-1:0];
                  r_in     = req_node_a[AW-1:0];
                  par_ra   = req_node_a[AW-1:0];
                  sel_in   = 1'b0;
                  state_in = ufds_pkg::ST_FIND1;
               end else if (need_b) begin
                  x_in     = req_node_b[AW-1:0];
                  r_in     = req_node_b[AW-1:0];
                  par_ra   = req_node_b[AW-1:0];
                  sel_in   = 1'b1;
                  state_in = ufds_pkg::ST_FIND1;
               end else if (req_opcode == ufds_pkg::OP_QUERY) begin
                  state_in = ufds_pkg::ST_ITEM_END;
               end else begin
                  // A merge that names a node outside the set is dropped.
                  state_in = ufds_pkg::ST_IDLE;
               end
            end
         end

         ufds_pkg::ST_FIND1: begin
            if (par_rd == r_ff) begin
               root_in  = r_ff;
               r_in     = x_ff;
               par_ra   = x_ff;
               state_in = ufds_pkg::ST_FIND2;
            end else begin
               r_in   = par_rd;
               par_ra = par_rd;
            end
         end

         ufds_pkg::ST_FIND2: begin
            if (r_ff == root_ff) begin
               if (!sel_ff) begin
                  ra_in = root_ff;
                  if (need_b_ff) begin
                     x_in     = b_ff;
                     r_in     = b_ff;
                     par_ra   = b_ff;
                     sel_in   = 1'b1;
                     state_in = ufds_pkg::ST_FIND1;
                  end else begin
                     state_in = ufds_pkg::ST_ITEM_END;
                  end
               end else begin
                  rb_in    = root_ff;
                  state_in = ufds_pkg::ST_ITEM_END;
               end
            end else begin
               par_we = 1'b1;
               par_wa = r_ff;
               par_wd = root_ff;
               r_in   = par_rd;
               par_ra = par_rd;
            end
         end

         ufds_pkg::ST_ITEM_END: begin
            if (op_ff == ufds_pkg::OP_QUERY) begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in    = 1'b1;
                  rsp_same_set_in = both_ok_ff ? (ra_ff == rb_ff) : eq_ff;
                  state_in        = ufds_pkg::ST_IDLE;
               end
            end else if (ra_ff == rb_ff) begin
               state_in = ufds_pkg::ST_IDLE;
            end else begin
               sz_ra    = ra_ff;
               state_in = ufds_pkg::ST_SIZE_A;
            end
         end

         ufds_pkg::ST_SIZE_A: begin
            size_a_in = sz_rd;
            sz_ra     = rb_ff;
            state_in  = ufds_pkg::ST_SIZE_B;
         end

         ufds_pkg::ST_SIZE_B: begin
            sz_we  = 1'b1;
            par_we = 1'b1;
            sz_wd  = size_sum;
            if (size_a_ff >= sz_rd) begin
               sz_wa  = ra_ff;
               par_wa = rb_ff;
               par_wd = ra_ff;
            end else begin
               sz_wa  = rb_ff;
               par_wa = ra_ff;
               par_wd = rb_ff;
            end
            state_in = ufds_pkg::ST_IDLE;
         end

         default: begin
            state_in = ufds_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_same_set = rsp_same_set_ff;

   `UFDS_ASSERT_IMPLY(a_rsp_from_query, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ufds_pkg::ST_ITEM_END) && $past(op_ff == ufds_pkg::OP_QUERY))
   `UFDS_ASSERT_NEVER(a_no_root_rewrite, clock, reset,
      par_we && (state_ff == ufds_pkg::ST_FIND2) && (par_wa == root_ff))
   `UFDS_ASSERT_NEVER(a_size_no_wrap, clock, reset,
      (state_ff == ufds_pkg::ST_SIZE_B) && (size_sum < size_a_ff))
   `UFDS_ASSERT_NEVER(a_link_distinct_roots, clock, reset,
      (state_ff == ufds_pkg::ST_SIZE_B) && (ra_ff == rb_ff))

endmodule
